### design/dlr_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the direction LED ring renderer.
// No dependencies.
package dlr_pkg;

   localparam int RING_SIZE  = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 40;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_LED     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE_ORDER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FAR_LEVEL     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NEAR_LEVEL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STALE_LIMIT   = 3'd4;

   localparam logic [3:0]         RST_FIRST_LED   = 4'd0;
   localparam logic               RST_REVERSE     = 1'b0;
   localparam logic signed [11:0] RST_FAR_LEVEL   = -12'sd960;
   localparam logic signed [11:0] RST_NEAR_LEVEL  = -12'sd320;
   localparam logic [15:0]        RST_STALE_LIMIT = 16'd10;

   // estimate status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_ZENITH = 2'd1;

   localparam logic signed [12:0] ELEV_MAX   = 13'sd1440;
   // six full circles in 1/16 degree, keeps the negated azimuth positive
   localparam logic [16:0]        AZ_OFFSET  = 17'd34560;
   localparam logic [7:0]         FULL_BRIGHT = 8'd255;
   localparam logic [7:0]         WORD_TAG   = 8'd4;
   // floor(y/15) = (y*RECIP_15) >> 15 for y below 4096
   localparam logic [11:0]        RECIP_15   = 12'd2185;
   // floor(q/12) = (q*RECIP_12) >> 11 for q below 256
   localparam logic [7:0]         RECIP_12   = 8'd171;
   localparam logic [16:0]        HALF_SECTOR = 17'd240;
   localparam logic [3:0]         LAST_LED   = 4'd11;

   typedef enum logic [1:0] {
      MODE_DARK,
      MODE_ZENITH,
      MODE_SPLIT
   } mode_type;

endpackage

### design/doa_led_ring_renderer.sv
`timescale 1ns / 1ps
// Direction LED ring renderer: turns direction estimates into twelve LED words.
// Depends on dlr_pkg.
//
// Usage:
//   req_* carries one direction estimate per transfer; rsp_* returns the
//   twelve words of the LED ring for it, physical positions 0 to 11 in order,
//   with rsp_tlast on position 11 and rsp_tuser set on every word when the
//   level window or first_led is invalid. csr_* writes one configuration
//   register per cycle; the user must write only while idle, unenforced.
// Pipeline:
//   An estimate runs through an eight-stage pipeline (level window, sector
//   reciprocal, four stages of a two-bit-per-stage divider for brightness,
//   share multiply, share rounding) and into the output register, which
//   sends its words. The output channel moves one word per cycle while
//   rsp_tready is high and so sets the throughput, twelve words per
//   estimate; the pipeline keeps up to eight more estimates queued.
// Reset restores the register defaults and empties the pipeline.
// When the receiver stalls the current word holds, the pipeline fills and
//   req_tready drops; nothing is lost or repeated.
module doa_led_ring_renderer (
   input  logic                          clock,
   input  logic                          reset,
   // [11:0] level, [24:12] elevation, [40:25] azimuth, [56:41] age
   input  logic [dlr_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] azimuth_ok, [2:1] status
   input  logic [dlr_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [3:0] led_index, [35:4] pixel_word
   output logic [dlr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] bad_config
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_wr_en,
   input  logic [dlr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dlr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dlr_pkg::*;

   function automatic logic [21:0] div_step(input logic [20:0] rem,
                                            input logic [12:0] d,
                                            input int          sh);
      logic [20:0] dsh;
      dsh = {8'd0, d} << sh;
      if (rem >= dsh) begin
         return {1'b1, rem - dsh};
      end
      return {1'b0, rem};
   endfunction

   // configuration registers
   logic [3:0]         first_led_ff;
   logic               reverse_ff;
   logic signed [11:0] far_ff;
   logic signed [11:0] near_ff;
   logic [15:0]        stale_ff;

   function automatic logic [3:0] phys_pos(input logic [3:0] l,
                                           input logic [3:0] f,
                                           input logic       rev);
      logic [4:0] s;
      if (rev) begin
         s = {1'b0, f} + 5'd12 - {1'b0, l};
      end else begin
         s = {1'b0, f} + {1'b0, l};
      end
      if (s >= 5'd12) begin
         s = s - 5'd12;
      end
      return s[3:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         first_led_ff <= RST_FIRST_LED;
         reverse_ff   <= RST_REVERSE;
         far_ff       <= RST_FAR_LEVEL;
         near_ff      <= RST_NEAR_LEVEL;
         stale_ff     <= RST_STALE_LIMIT;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FIRST_LED:     first_led_ff <= csr_wdata[3:0];
            REG_REVERSE_ORDER: reverse_ff   <= csr_wdata[0];
            REG_FAR_LEVEL:     far_ff       <= csr_wdata[11:0];
            REG_NEAR_LEVEL:    near_ff      <= csr_wdata[11:0];
            REG_STALE_LIMIT:   stale_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input fields
   logic signed [11:0] in_level;
   logic signed [12:0] in_elev;
   logic signed [15:0] in_az;
   logic [15:0]        in_age;
   logic               in_az_ok;
   logic [1:0]         in_status;

   assign in_level  = req_tdata[11:0];
   assign in_elev   = req_tdata[24:12];
   assign in_az     = req_tdata[40:25];
   assign in_age    = req_tdata[56:41];
   assign in_az_ok  = req_tuser[0];
   assign in_status = req_tuser[2:1];

   logic advance;
   logic load;

   // stage valid bits
   logic [8:1] v_ff;
   logic [8:1] v_in;

   // stage 1: level window, mode, unfolded azimuth
   logic signed [12:0] s1_num_ff, s1_num_in;
   logic signed [12:0] s1_den_ff, s1_den_in;
   logic [16:0]        s1_x_ff, s1_x_in;
   mode_type           s1_mode_ff, s1_mode_in;
   logic               s1_bad_ff, s1_bad_in;

   // stage 2: clamp, dividend, sector quotient
   logic [20:0] s2_n_ff, s2_n_in;
   logic [12:0] s2_d_ff, s2_d_in;
   logic        s2_zero_ff, s2_zero_in;
   logic        s2_full_ff, s2_full_in;
   logic [7:0]  s2_q_ff, s2_q_in;
   logic [16:0] s2_x_ff, s2_x_in;
   mode_type    s2_mode_ff, s2_mode_in;
   logic        s2_bad_ff, s2_bad_in;

   // stages 3 to 6: brightness divider, two quotient bits per stage
   logic [20:0] s3_rem_ff, s3_rem_in, s4_rem_ff, s4_rem_in, s5_rem_ff, s5_rem_in;
   logic [12:0] s3_d_ff, s3_d_in, s4_d_ff, s4_d_in, s5_d_ff, s5_d_in;
   logic [7:0]  s3_qd_ff, s3_qd_in, s4_qd_ff, s4_qd_in, s5_qd_ff, s5_qd_in;
   logic [3:0]  s3_zf_ff, s3_zf_in;
   logic        s4_zero_ff, s4_zero_in, s4_full_ff, s4_full_in;
   logic        s5_zero_ff, s5_zero_in, s5_full_ff, s5_full_in;
   logic [7:0]  s3_q_ff, s3_q_in;
   logic [3:0]  s3_qq_ff, s3_qq_in;
   logic [8:0]  s3_r_ff, s3_r_in, s4_r_ff, s4_r_in, s5_r_ff, s5_r_in, s6_r_ff, s6_r_in;
   logic [3:0]  s4_a_ff, s4_a_in, s5_a_ff, s5_a_in, s6_a_ff, s6_a_in;
   mode_type    s3_mode_ff, s3_mode_in, s4_mode_ff, s4_mode_in;
   mode_type    s5_mode_ff, s5_mode_in, s6_mode_ff, s6_mode_in;
   logic        s3_bad_ff, s3_bad_in, s4_bad_ff, s4_bad_in;
   logic        s5_bad_ff, s5_bad_in, s6_bad_ff, s6_bad_in;
   logic [7:0]  s6_b_ff, s6_b_in;

   // stage 7: share product
   logic [16:0] s7_p_ff, s7_p_in;
   logic [16:0] s7_bx_ff, s7_bx_in;
   logic [7:0]  s7_b_ff, s7_b_in;
   logic [3:0]  s7_a_ff, s7_a_in;
   mode_type    s7_mode_ff, s7_mode_in;
   logic        s7_bad_ff, s7_bad_in;

   // stage 8: rounded shares
   logic [7:0]  s8_va_ff, s8_va_in;
   logic [7:0]  s8_vb_ff, s8_vb_in;
   logic [7:0]  s8_b_ff, s8_b_in;
   logic [3:0]  s8_a_ff, s8_a_in;
   mode_type    s8_mode_ff, s8_mode_in;
   logic        s8_bad_ff, s8_bad_in;

   always_comb begin
      logic [21:0] st_hi;
      logic [21:0] st_lo;
      logic [23:0] rq;
      logic [15:0] rqq;
      logic [16:0] q480;
      logic [7:0]  a_full;
      logic [16:0] tb;
      logic [16:0] ta;
      logic [23:0] pva;
      logic [23:0] pvb;

      v_in = {v_ff[7:1], req_tvalid};

      // stage 1
      s1_bad_in = (near_ff <= far_ff) || (first_led_ff >= 4'd12);
      s1_num_in = {in_level[11], in_level} - {far_ff[11], far_ff};
      s1_den_in = {near_ff[11], near_ff} - {far_ff[11], far_ff};
      s1_x_in   = AZ_OFFSET - {in_az[15], in_az};
      if (s1_bad_in || (in_age > stale_ff) || (in_elev < 13'sd0) ||
          (in_elev > ELEV_MAX)) begin
         s1_mode_in = MODE_DARK;
      end else if (in_status == STATUS_ZENITH) begin
         s1_mode_in = MODE_ZENITH;
      end else if (in_status == STATUS_OK && in_az_ok) begin
         s1_mode_in = MODE_SPLIT;
      end else begin
         s1_mode_in = MODE_DARK;
      end

      // stage 2: dividend 510*num + den over divisor 2*den
      s2_zero_in = (s1_num_ff <= 13'sd0);
      s2_full_in = (s1_num_ff >= s1_den_ff);
      s2_n_in    = {s1_num_ff[11:0], 9'd0} - {8'd0, s1_num_ff[11:0], 1'b0}
                   + {9'd0, s1_den_ff[11:0]};
      s2_d_in    = {s1_den_ff[11:0], 1'b0};
      rq         = {12'd0, s1_x_ff[16:5]} * {12'd0, RECIP_15};
      s2_q_in    = rq[22:15];
      s2_x_in    = s1_x_ff;
      s2_mode_in = s1_mode_ff;
      s2_bad_in  = s1_bad_ff;

      // stage 3: quotient bits 7 and 6, sector remainder
      st_hi      = div_step(s2_n_ff, s2_d_ff, 7);
      st_lo      = div_step(st_hi[20:0], s2_d_ff, 6);
      s3_rem_in  = st_lo[20:0];
      s3_qd_in   = {st_hi[21], st_lo[21], 6'd0};
      s3_d_in    = s2_d_ff;
      s3_zf_in   = {2'd0, s2_zero_ff, s2_full_ff};
      q480       = {s2_q_ff, 9'd0} - {4'd0, s2_q_ff, 5'd0};
      s3_r_in    = 9'(s2_x_ff - q480);
      s3_q_in    = s2_q_ff;
      rqq        = {8'd0, s2_q_ff} * {8'd0, RECIP_12};
      s3_qq_in   = rqq[14:11];
      s3_mode_in = s2_mode_ff;
      s3_bad_in  = s2_bad_ff;

      // stage 4: bits 5 and 4, sector index within the ring
      st_hi      = div_step(s3_rem_ff, s3_d_ff, 5);
      st_lo      = div_step(st_hi[20:0], s3_d_ff, 4);
      s4_rem_in  = st_lo[20:0];
      s4_qd_in   = {s3_qd_ff[7:6], st_hi[21], st_lo[21], 4'd0};
      s4_d_in    = s3_d_ff;
      s4_zero_in = s3_zf_ff[1];
      s4_full_in = s3_zf_ff[0];
      a_full     = s3_q_ff - {1'b0, s3_qq_ff, 3'd0} - {2'd0, s3_qq_ff, 2'd0};
      s4_a_in    = a_full[3:0];
      s4_r_in    = s3_r_ff;
      s4_mode_in = s3_mode_ff;
      s4_bad_in  = s3_bad_ff;

      // stage 5: bits 3 and 2
      st_hi      = div_step(s4_rem_ff, s4_d_ff, 3);
      st_lo      = div_step(st_hi[20:0], s4_d_ff, 2);
      s5_rem_in  = st_lo[20:0];
      s5_qd_in   = {s4_qd_ff[7:4], st_hi[21], st_lo[21], 2'd0};
      s5_d_in    = s4_d_ff;
      s5_zero_in = s4_zero_ff;
      s5_full_in = s4_full_ff;
      s5_a_in    = s4_a_ff;
      s5_r_in    = s4_r_ff;
      s5_mode_in = s4_mode_ff;
      s5_bad_in  = s4_bad_ff;

      // stage 6: bits 1 and 0, clamp
      st_hi      = div_step(s5_rem_ff, s5_d_ff, 1);
      st_lo      = div_step(st_hi[20:0], s5_d_ff, 0);
      if (s5_zero_ff) begin
         s6_b_in = 8'd0;
      end else if (s5_full_ff) begin
         s6_b_in = FULL_BRIGHT;
      end else begin
         s6_b_in = {s5_qd_ff[7:2], st_hi[21], st_lo[21]};
      end
      s6_a_in    = s5_a_ff;
      s6_r_in    = s5_r_ff;
      s6_mode_in = s5_mode_ff;
      s6_bad_in  = s5_bad_ff;

      // stage 7
      s7_p_in    = {9'd0, s6_b_ff} * {8'd0, s6_r_ff};
      s7_bx_in   = {s6_b_ff, 9'd0} - {4'd0, s6_b_ff, 5'd0};
      s7_b_in    = s6_b_ff;
      s7_a_in    = s6_a_ff;
      s7_mode_in = s6_mode_ff;
      s7_bad_in  = s6_bad_ff;

      // stage 8: round half up, divide by 480 as shift by 5 then by 15
      tb         = s7_p_ff + HALF_SECTOR;
      ta         = s7_bx_ff - s7_p_ff + HALF_SECTOR;
      pvb        = {12'd0, tb[16:5]} * {12'd0, RECIP_15};
      pva        = {12'd0, ta[16:5]} * {12'd0, RECIP_15};
      s8_vb_in   = pvb[22:15];
      s8_va_in   = pva[22:15];
      s8_b_in    = s7_b_ff;
      s8_a_in    = s7_a_ff;
      s8_mode_in = s7_mode_ff;
      s8_bad_in  = s7_bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_num_ff  <= s1_num_in;  s1_den_ff  <= s1_den_in;  s1_x_ff    <= s1_x_in;
         s1_mode_ff <= s1_mode_in; s1_bad_ff  <= s1_bad_in;
         s2_n_ff    <= s2_n_in;    s2_d_ff    <= s2_d_in;    s2_zero_ff <= s2_zero_in;
         s2_full_ff <= s2_full_in; s2_q_ff    <= s2_q_in;    s2_x_ff    <= s2_x_in;
         s2_mode_ff <= s2_mode_in; s2_bad_ff  <= s2_bad_in;
         s3_rem_ff  <= s3_rem_in;  s3_d_ff    <= s3_d_in;    s3_qd_ff   <= s3_qd_in;
         s3_zf_ff   <= s3_zf_in;   s3_q_ff    <= s3_q_in;    s3_qq_ff   <= s3_qq_in;
         s3_r_ff    <= s3_r_in;    s3_mode_ff <= s3_mode_in; s3_bad_ff  <= s3_bad_in;
         s4_rem_ff  <= s4_rem_in;  s4_d_ff    <= s4_d_in;    s4_qd_ff   <= s4_qd_in;
         s4_zero_ff <= s4_zero_in; s4_full_ff <= s4_full_in; s4_a_ff    <= s4_a_in;
         s4_r_ff    <= s4_r_in;    s4_mode_ff <= s4_mode_in; s4_bad_ff  <= s4_bad_in;
         s5_rem_ff  <= s5_rem_in;  s5_d_ff    <= s5_d_in;    s5_qd_ff   <= s5_qd_in;
         s5_zero_ff <= s5_zero_in; s5_full_ff <= s5_full_in; s5_a_ff    <= s5_a_in;
         s5_r_ff    <= s5_r_in;    s5_mode_ff <= s5_mode_in; s5_bad_ff  <= s5_bad_in;
         s6_b_ff    <= s6_b_in;    s6_a_ff    <= s6_a_in;    s6_r_ff    <= s6_r_in;
         s6_mode_ff <= s6_mode_in; s6_bad_ff  <= s6_bad_in;
         s7_p_ff    <= s7_p_in;    s7_bx_ff   <= s7_bx_in;   s7_b_ff    <= s7_b_in;
         s7_a_ff    <= s7_a_in;    s7_mode_ff <= s7_mode_in; s7_bad_ff  <= s7_bad_in;
         s8_va_ff   <= s8_va_in;   s8_vb_ff   <= s8_vb_in;   s8_b_ff    <= s8_b_in;
         s8_a_ff    <= s8_a_in;    s8_mode_ff <= s8_mode_in; s8_bad_ff  <= s8_bad_in;
      end
   end

   // output register: one ring at a time, one word per transfer
   logic       busy_ff, busy_in;
   logic [3:0] cnt_ff, cnt_in;
   mode_type   h_mode_ff, h_mode_in;
   logic       h_bad_ff, h_bad_in;
   logic [7:0] h_b_ff, h_b_in, h_va_ff, h_va_in, h_vb_ff, h_vb_in;
   logic [3:0] h_p0_ff, h_p0_in, h_p6_ff, h_p6_in, h_pa_ff, h_pa_in, h_pb_ff, h_pb_in;
   logic       out_fire;
   logic       done;
   logic [31:0] word;

   assign out_fire = busy_ff && rsp_tready;
   assign done     = out_fire && (cnt_ff == LAST_LED);
   assign load     = v_ff[8] && (!busy_ff || done);
   assign advance  = !v_ff[8] || load;
   assign req_tready = advance;

   always_comb begin
      logic [3:0] a_next;
      a_next    = (s8_a_ff == LAST_LED) ? 4'd0 : s8_a_ff + 4'd1;
      h_bad_in  = s8_bad_ff;
      h_b_in    = s8_b_ff;
      h_va_in   = s8_va_ff;
      h_vb_in   = s8_vb_ff;
      h_mode_in = (s8_b_ff == 8'd0) ? MODE_DARK : s8_mode_ff;
      h_p0_in   = phys_pos(4'd0, first_led_ff, reverse_ff);
      h_p6_in   = phys_pos(4'd6, first_led_ff, reverse_ff);
      h_pa_in   = phys_pos(s8_a_ff, first_led_ff, reverse_ff);
      h_pb_in   = phys_pos(a_next, first_led_ff, reverse_ff);

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (out_fire) begin
         cnt_in = cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         h_mode_ff <= h_mode_in; h_bad_ff <= h_bad_in;
         h_b_ff    <= h_b_in;    h_va_ff  <= h_va_in;  h_vb_ff <= h_vb_in;
         h_p0_ff   <= h_p0_in;   h_p6_ff  <= h_p6_in;
         h_pa_ff   <= h_pa_in;   h_pb_ff  <= h_pb_in;
      end
   end

   always_comb begin
      word = 32'd0;
      case (h_mode_ff)
         MODE_ZENITH: begin
            if (cnt_ff == h_p0_ff || cnt_ff == h_p6_ff) begin
               word = {WORD_TAG, h_b_ff, 16'd0};
            end
         end
         MODE_SPLIT: begin
            if (cnt_ff == h_pa_ff && h_va_ff != 8'd0) begin
               word = {WORD_TAG, 8'd0, h_va_ff, 8'd0};
            end else if (cnt_ff == h_pb_ff && h_vb_ff != 8'd0) begin
               word = {WORD_TAG, 8'd0, h_vb_ff, 8'd0};
            end
         end
         default: word = 32'd0;
      endcase
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {4'd0, word, cnt_ff};
   assign rsp_tlast  = (cnt_ff == LAST_LED);
   assign rsp_tuser  = h_bad_ff;

   a_bad_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[35:4] == 32'd0))
      else $error("word lit under a configuration error");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (out_fire && cnt_ff != LAST_LED) |=> (cnt_ff == $past(cnt_ff) + 4'd1))
      else $error("word counter skipped or repeated a position");

   a_ring_end: assert property (@(posedge clock) disable iff (reset)
      (done && !v_ff[8]) |=> !rsp_tvalid)
      else $error("output still valid after the last word of a ring");

endmodule
